@@ rtl/core/qbpl_pkg.sv @@
// Shared types and fixed widths for the quadratic Bezier polyline length block.
`default_nettype none

package qbpl_pkg;

    // Coordinate width of one control point field.
    localparam int COORD_W = 16;

    // Per-segment coordinate delta, sized for the largest segment count (128):
    // |2N(b-a) + (2i-1)(a-2b+c)| < 2^26, so 27 signed bits.
    localparam int DX_W = 27;

    // Sum of two squared deltas, held unsigned; below 2^53.
    localparam int SQ_W = 2 * DX_W;

    // Root of a squared chord, and one root pipeline stage per result bit.
    localparam int ROOT_W      = DX_W;
    localparam int ROOT_STAGES = SQ_W / 2;

    // Scaled chord sum: up to 128 roots of 27 bits.
    localparam int SUM_W = 34;

    // Result width.
    localparam int QUOT_W = 18;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the control points, clear the sum
        logic step;       // issue one chord, advance the deltas
        logic div_load;   // form the quotient estimate by reciprocal multiply
        logic div_step;   // raise the estimate by one where the remainder allows
    } qbpl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;  // chords still in the square and root pipeline
    } qbpl_status_t;

endpackage

`default_nettype wire

@@ rtl/core/qbpl_isqrt.sv @@
// Pipelined integer square root, rounded down, one result bit per stage.
`default_nettype none

module qbpl_isqrt
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_vld,
    input  wire logic [qbpl_pkg::SQ_W-1:0]     in_sq,
    output logic                               out_vld,
    output logic [qbpl_pkg::ROOT_W-1:0]        out_root,
    output logic                               busy
);

    localparam int STAGES = qbpl_pkg::ROOT_STAGES;
    localparam int W      = qbpl_pkg::SQ_W;

    logic [STAGES:0]  vld_reg;
    logic [W-1:0]     v_reg  [0:STAGES];
    logic [W-1:0]     r_reg  [0:STAGES];
    logic [W-1:0]     v_next [1:STAGES];
    logic [W-1:0]     r_next [1:STAGES];
    logic [W-1:0]     trial  [0:STAGES-1];
    logic [W-1:0]     bitv   [0:STAGES-1];

    // Each stage tries the next bit pair, highest first.
    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            bitv[s]  = W'(1) << (2 * (STAGES - 1 - s));
            trial[s] = r_reg[s] + bitv[s];
            if (v_reg[s] >= trial[s])
            begin
                v_next[s + 1] = v_reg[s] - trial[s];
                r_next[s + 1] = (r_reg[s] >> 1) + bitv[s];
            end
            else
            begin
                v_next[s + 1] = v_reg[s];
                r_next[s + 1] = r_reg[s] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg[0] <= in_sq;
        r_reg[0] <= '0;
        for (int s = 1; s <= STAGES; s++)
        begin
            v_reg[s] <= v_next[s];
            r_reg[s] <= r_next[s];
        end
    end

    assign out_vld  = vld_reg[STAGES];
    assign out_root = r_reg[STAGES][qbpl_pkg::ROOT_W-1:0];
    assign busy     = |vld_reg;

endmodule

`default_nettype wire

@@ rtl/core/qbpl_dpath.sv @@
// Datapath: forward-difference deltas, squares, root pipeline, sum and divider.
`default_nettype none

module qbpl_dpath
#(
    parameter int SEGMENTS = 100
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire qbpl_pkg::qbpl_cmd_t                  cmd,
    output qbpl_pkg::qbpl_status_t                    status,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  start_x,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  start_y,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  ctrl_x,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  ctrl_y,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  end_x,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  end_y,
    output logic [qbpl_pkg::QUOT_W-1:0]               curve_length
);

    localparam int DX_W   = qbpl_pkg::DX_W;
    localparam int SQ_W   = qbpl_pkg::SQ_W;
    localparam int SUM_W  = qbpl_pkg::SUM_W;
    localparam int QUOT_W = qbpl_pkg::QUOT_W;
    localparam int NN     = SEGMENTS * SEGMENTS;

    // The sum stays below NN * 2^QUOT_W, so floor(2^DIV_SH / NN) leaves the
    // estimate at most one below the true quotient.
    localparam int DIV_SH  = $clog2(NN) + QUOT_W;
    localparam int RECIP_W = QUOT_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;

    localparam logic signed [DX_W-1:0] TWO_N = DX_W'(2 * SEGMENTS);
    localparam logic [RECIP_W-1:0]     RECIP = RECIP_W'((64'd1 << DIV_SH) / NN);
    localparam logic [SUM_W-1:0]       NN_S  = SUM_W'(NN);

    logic signed [DX_W-1:0]  ba_x, ba_y, curv_x, curv_y;
    logic signed [DX_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic signed [DX_W-1:0]  ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic signed [SQ_W-1:0]  sqx_full, sqy_full;
    logic [SQ_W-1:0]         mx_reg, my_reg;
    logic                    m_vld_reg;
    logic [SUM_W-1:0]        acc_reg, acc_next;
    logic [QUOT_W-1:0]       quot_reg, quot_next;
    logic [PROD_W-1:0]       recip_prod;
    logic [SUM_W-1:0]        est_back, est_rem;
    logic                    root_vld;
    logic [qbpl_pkg::ROOT_W-1:0] root;
    logic                    sqrt_busy;

    // Chord i delta is 2N(b-a) + (2i-1)(a-2b+c), scaled by N^2.
    always_comb
    begin
        ba_x   = DX_W'(ctrl_x) - DX_W'(start_x);
        ba_y   = DX_W'(ctrl_y) - DX_W'(start_y);
        curv_x = DX_W'(start_x) - (DX_W'(ctrl_x) <<< 1) + DX_W'(end_x);
        curv_y = DX_W'(start_y) - (DX_W'(ctrl_y) <<< 1) + DX_W'(end_y);

        dx_next  = dx_reg;
        dy_next  = dy_reg;
        ddx_next = ddx_reg;
        ddy_next = ddy_reg;
        if (cmd.load)
        begin
            dx_next  = ba_x * TWO_N + curv_x;
            dy_next  = ba_y * TWO_N + curv_y;
            ddx_next = curv_x <<< 1;
            ddy_next = curv_y <<< 1;
        end
        else if (cmd.step)
        begin
            dx_next = dx_reg + ddx_reg;
            dy_next = dy_reg + ddy_reg;
        end
    end

    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    qbpl_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (m_vld_reg),
        .in_sq    (mx_reg + my_reg),
        .out_vld  (root_vld),
        .out_root (root),
        .busy     (sqrt_busy)
    );

    // Accumulate roots; divide the sum by N^2 through a reciprocal multiply,
    // then lift the estimate by one if the remainder still holds N^2.
    always_comb
    begin
        recip_prod = PROD_W'(acc_reg) * PROD_W'(RECIP);
        est_back   = SUM_W'(quot_reg) * NN_S;
        est_rem    = acc_reg - est_back;

        acc_next  = acc_reg;
        quot_next = quot_reg;
        if (cmd.load)
        begin
            acc_next = '0;
        end
        else if (root_vld)
        begin
            acc_next = acc_reg + SUM_W'(root);
        end
        if (cmd.div_load)
        begin
            quot_next = recip_prod[DIV_SH +: QUOT_W];
        end
        if (cmd.div_step)
        begin
            if (est_rem >= NN_S)
            begin
                quot_next = quot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= cmd.step;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        ddx_reg  <= ddx_next;
        ddy_reg  <= ddy_next;
        mx_reg   <= unsigned'(sqx_full);
        my_reg   <= unsigned'(sqy_full);
        acc_reg  <= acc_next;
        quot_reg <= quot_next;
    end

    assign status.pipe_busy = m_vld_reg | sqrt_busy;
    assign curve_length     = quot_reg;

endmodule

`default_nettype wire

@@ rtl/core/qbpl_ctrl.sv @@
// Controller: sequences chord issue, pipeline drain, division and result strobe.
`default_nettype none

module qbpl_ctrl
#(
    parameter int SEGMENTS = 100
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    output logic                         done,
    output qbpl_pkg::qbpl_cmd_t          cmd,
    input  wire qbpl_pkg::qbpl_status_t  status
);

    localparam int CNT_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RUN    = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] seg_cnt_reg, seg_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        seg_cnt_next = seg_cnt_reg;
        cmd          = '0;
        done         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    seg_cnt_next = '0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (seg_cnt_reg == CNT_W'(SEGMENTS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    seg_cnt_next = seg_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seg_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            seg_cnt_reg <= seg_cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/quadratic_bezier_polyline_length_top.sv @@
// Top level of the quadratic Bezier polyline length estimator.
//
// Usage: drive the three control points (start, ctrl, end; signed 16-bit x/y)
// and raise start. A request is taken at the rising edge where start is high
// and busy is low; the points are captured at that edge and need not be held.
// The curve is cut into SEGMENTS chords. Each chord delta comes from a
// forward-difference step, is squared on two 27x27 multipliers, and enters a
// 27-stage root pipeline, one chord per cycle. The roots are summed, then
// divided by SEGMENTS^2 with a reciprocal multiply and one correction step.
// A request runs through the chord issue, the multiplier register and the
// root pipeline, one drain check, the divide (one estimate and one
// correction), and the strobe. busy stays high until done, so one request
// is in flight at a time; the next can be taken the cycle after done.
// done is high for exactly one cycle with curve_length valid; the receiver
// cannot stall, so capture it then (curve_length holds until the next run).
// Reset (rst_n low, asynchronous) returns the controller to idle and drops
// any request in flight; no result is produced for it.
`default_nettype none

module quadratic_bezier_polyline_length_top
#(
    parameter int SEGMENTS = 100
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  start_x,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  start_y,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  ctrl_x,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  ctrl_y,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  end_x,
    input  wire logic signed [qbpl_pkg::COORD_W-1:0]  end_y,
    output logic                                      done,
    output logic [qbpl_pkg::QUOT_W-1:0]               curve_length
);

    qbpl_pkg::qbpl_cmd_t    cmd;
    qbpl_pkg::qbpl_status_t status;

    // Sequence each request: issue chords, drain, divide, strobe.
    qbpl_ctrl #(.SEGMENTS(SEGMENTS)) u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    // Hold all arithmetic: deltas, squares, roots, sum and quotient.
    qbpl_dpath #(.SEGMENTS(SEGMENTS)) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .start_x      (start_x),
        .start_y      (start_y),
        .ctrl_x       (ctrl_x),
        .ctrl_y       (ctrl_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .curve_length (curve_length)
    );

    // Nothing may be left in the pipeline while idle.
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !status.pipe_busy)
        else $error("chord pipeline active while idle");

    // The divider must only run on a fully accumulated sum.
    a_div_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_load || cmd.div_step) |-> !status.pipe_busy)
        else $error("division started with chords in flight");

    // An accepted request keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // The result strobe ends the request.
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("block still busy after result strobe");

endmodule

`default_nettype wire
